// ----- design/mbps_pkg.sv -----
// Shared constants, types and helpers for the masked byte pattern search unit.
package mbps_pkg;

    // Sizing of the search window and address space
    localparam int PATTERN_MAX = 32;
    localparam int ADDR_BITS   = 48;

    // Fixed field widths
    localparam int ADDR_W     = 48;
    localparam int DATA_W     = 8;
    localparam int LEN_W      = 6;
    localparam int ALIGN_W    = 4;
    localparam int MASK_W     = 32;
    localparam int PWORD_W    = 64;
    localparam int PWORD_N    = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_ADDR_W = CFG_IDX_W + 3;

    // Derived sizes
    localparam int RUN_W     = $clog2(PATTERN_MAX + 1);
    localparam int WIN_IDX_W = $clog2(PATTERN_MAX);

    // Address mask: all ones in the low ADDR_BITS bits of the address field
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
        ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    // Register reset values
    localparam logic [MASK_W-1:0]  CARE_RESET  = {MASK_W{1'b1}};
    localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1);

    // Configuration register map, one 8-byte slot each
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN0 = 3'd0,
        REG_PATTERN1 = 3'd1,
        REG_PATTERN2 = 3'd2,
        REG_PATTERN3 = 3'd3,
        REG_CARE     = 3'd4,
        REG_LENGTH   = 3'd5,
        REG_ALIGN    = 3'd6,
        REG_BOUND    = 3'd7
    } t_cfg_idx;

    // Effective pattern length: zero acts as one, clamp at window depth
    function automatic logic [LEN_W-1:0] used_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(PATTERN_MAX)) begin
            res = LEN_W'(PATTERN_MAX);
        end
        return res;
    endfunction

endpackage

// ----- design/mbps_in_if.sv -----
// Input channel: one memory byte per beat with its address and scan markers.
interface mbps_in_if;
    import mbps_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] byte_addr;
    logic [DATA_W-1:0] data_byte;
    logic              first;
    logic              last;

    modport source (output valid, output byte_addr, output data_byte,
                    output first, output last, input ready);
    modport sink   (input valid, input byte_addr, input data_byte,
                    input first, input last, output ready);
endinterface

// ----- design/mbps_out_if.sv -----
// Output channel: one search result per beat.
interface mbps_out_if;
    import mbps_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] match_addr;

    modport source (output valid, output found, output match_addr, input ready);
    modport sink   (input valid, input found, input match_addr, output ready);
endinterface

// ----- design/masked_byte_pattern_search_unit.sv -----
// Masked byte pattern search: window register, match stage and result register.
// A byte accepted into the window register yields its result (if any) on o_result via the result register.
// Throughput: one byte per cycle; the window compare is a single registered stage.
// Input stalls only while the match stage holds a result, the result register is full
// and o_result.ready is low.
// Reset (synchronous, active low) empties the pipeline, clears run count and done flag,
// and returns all configuration registers to their reset values.
module masked_byte_pattern_search_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mbps_in_if.sink                          i_item,
    mbps_out_if.source                       o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbps_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [mbps_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import mbps_pkg::*;

    // Configuration registers
    logic [PWORD_W-1:0] r_pat [PWORD_N];
    logic [MASK_W-1:0]  r_care;
    logic [LEN_W-1:0]   r_len;
    logic [ALIGN_W-1:0] r_align;
    logic [ADDR_W-1:0]  r_bound;

    // Window stage
    logic [DATA_W-1:0]  r_win [PATTERN_MAX];
    logic [RUN_W-1:0]   r_run;
    logic [RUN_W-1:0]   n_run;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_s1_valid;
    logic               r_s1_first;
    logic               r_s1_last;
    logic               r_done;
    logic               n_done;

    // Result register
    logic               r_out_valid;
    logic               r_out_found;
    logic [ADDR_W-1:0]  r_out_addr;

    logic               cfg_wr;
    t_cfg_idx           cfg_idx;
    logic               in_fire;
    logic [ADDR_W-1:0]  addr_in;
    logic               run_break;
    logic [LEN_W-1:0]   ulen;
    logic [ADDR_W-1:0]  start;
    logic [ADDR_W-1:0]  align_mask;
    logic               bytes_ok;
    logic               match;
    logic               s1_result;
    logic               out_free;
    logic               s1_go;
    logic               s1_retire;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = t_cfg_idx'(paddr[CFG_ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < PWORD_N; w++) begin
                r_pat[w] <= '0;
            end
            r_care  <= CARE_RESET;
            r_len   <= LEN_RESET;
            r_align <= '0;
            r_bound <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PATTERN0: r_pat[0] <= pwdata;
                REG_PATTERN1: r_pat[1] <= pwdata;
                REG_PATTERN2: r_pat[2] <= pwdata;
                REG_PATTERN3: r_pat[3] <= pwdata;
                REG_CARE:     r_care   <= pwdata[MASK_W-1:0];
                REG_LENGTH:   r_len    <= pwdata[LEN_W-1:0];
                REG_ALIGN:    r_align  <= pwdata[ALIGN_W-1:0];
                REG_BOUND:    r_bound  <= pwdata[ADDR_W-1:0] & ADDR_MASK;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (cfg_idx)
            REG_PATTERN0: prdata = r_pat[0];
            REG_PATTERN1: prdata = r_pat[1];
            REG_PATTERN2: prdata = r_pat[2];
            REG_PATTERN3: prdata = r_pat[3];
            REG_CARE:     prdata = CFG_DATA_W'(r_care);
            REG_LENGTH:   prdata = CFG_DATA_W'(r_len);
            REG_ALIGN:    prdata = CFG_DATA_W'(r_align);
            REG_BOUND:    prdata = CFG_DATA_W'(r_bound);
            default:      prdata = '0;
        endcase
    end

    // ---------------- window stage ----------------
    assign in_fire = i_item.valid && i_item.ready;
    assign addr_in = i_item.byte_addr & ADDR_MASK;

    // Run breaks on a new scan, an address gap or a wrap past the top
    assign run_break = i_item.first || (r_addr == ADDR_MASK) ||
                       (addr_in != r_addr + ADDR_W'(1));

    always_comb begin
        if (run_break) begin
            n_run = RUN_W'(1);
        end else if (r_run < RUN_W'(PATTERN_MAX)) begin
            n_run = r_run + RUN_W'(1);
        end else begin
            n_run = r_run;
        end
    end

    // Window shift line, newest byte in entry 0; stale entries never decide a match
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_win[0] <= i_item.data_byte;
            for (int k = 1; k < PATTERN_MAX; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_addr <= '0;
        end else if (in_fire) begin
            r_run  <= n_run;
            r_addr <= addr_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_first <= i_item.first;
            r_s1_last  <= i_item.last;
        end
    end

    // ---------------- match stage ----------------
    assign ulen       = used_len(r_len);
    assign start      = r_addr - ADDR_W'(ulen - LEN_W'(1));
    assign align_mask = (ADDR_W'(1) << r_align) - ADDR_W'(1);

    // Pattern byte i lines up with window entry ulen-1-i
    always_comb begin
        logic [LEN_W-1:0] idx;
        bytes_ok = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            idx = ulen - LEN_W'(1) - LEN_W'(i);
            if ((LEN_W'(i) < ulen) && r_care[i] &&
                (r_win[idx[WIN_IDX_W-1:0]] != r_pat[i/8][(i%8)*8 +: 8])) begin
                bytes_ok = 1'b0;
            end
        end
    end

    assign match = (LEN_W'(r_run) >= ulen) && bytes_ok &&
                   (start >= r_bound) && ((start & align_mask) == '0);

    // A new scan reopens the search even after a reported result
    assign s1_result = r_s1_valid && (r_s1_first || !r_done) && (match || r_s1_last);
    assign out_free  = !r_out_valid || o_result.ready;
    assign s1_go     = !r_s1_valid || !s1_result || out_free;
    assign s1_retire = r_s1_valid && s1_go;

    assign i_item.ready = s1_go;

    always_comb begin
        n_done = r_done;
        if (s1_retire) begin
            n_done = (r_s1_first ? 1'b0 : r_done) | s1_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (s1_go) begin
                r_s1_valid <= i_item.valid;
            end
            r_done <= n_done;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_retire && s1_result) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_retire && s1_result) begin
            r_out_found <= match;
            r_out_addr  <= match ? start : '0;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.found      = r_out_found;
    assign o_result.match_addr = r_out_addr;

    // ---------------- checks ----------------
    // A held byte always belongs to a run of at least one byte
    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_run != '0) && (r_run <= RUN_W'(PATTERN_MAX)))
        else $error("run count out of range with a byte in the match stage");

    // With the result register empty the input is never held off
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_item.ready)
        else $error("input stalled while result register empty");

    // Not-found results carry a zero address
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> (r_out_addr == '0))
        else $error("not-found result with nonzero address");

    // Done flag only rises when a byte leaves the match stage
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(s1_retire && s1_result))
        else $error("done flag set without a delivered result");

endmodule
